// ===== hw/rtl/mtg_pkg.sv =====
// shared types, constants and word functions of the mt19937 generator core
// no dependencies; imported by mersenne_twister_generator_core and the testbench
package mtg_pkg;

   localparam int StateWords  = 624;
   localparam int ShiftOffset = 397;
   localparam int FarWrap     = StateWords - ShiftOffset;
   localparam int WordWidth   = 32;
   localparam int IdxWidth    = $clog2(StateWords + 2);

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [IdxWidth-1:0]  idx_type;

   localparam idx_type  LastWord        = idx_type'(StateWords - 1);
   localparam idx_type  BlockUsedUp     = idx_type'(StateWords);
   localparam idx_type  NotSeeded       = idx_type'(StateWords + 1);
   localparam word_type DefaultSeedInit = 32'd5489;
   localparam word_type InitMult        = 32'd1812433253;
   localparam word_type TwistXor        = 32'h9908b0df;
   localparam word_type TemperMaskB     = 32'h9d2c5680;
   localparam word_type TemperMaskC     = 32'hefc60000;

   localparam logic KIND_SEED = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_SEED_DONE,
      ST_READ,
      ST_TWIST
   } fsm_state_type;

   function automatic word_type init_next(word_type prev, idx_type pos);
      word_type x;
      x = prev ^ (prev >> 30);
      return word_type'(x * InitMult) + word_type'(pos);
   endfunction

   function automatic word_type twist_word(word_type cur, word_type nxt, word_type far);
      word_type y;
      y = {cur[WordWidth-1], nxt[WordWidth-2:0]};
      return far ^ (y >> 1) ^ (y[0] ? TwistXor : '0);
   endfunction

   function automatic word_type temper(word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TemperMaskB);
      y = y ^ ((y << 15) & TemperMaskC);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== hw/rtl/mtg_state_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
// no dependencies; holds the twister state words
module mtg_state_ram #(
   parameter int Depth     = 624,
   parameter int Width     = 32,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr_a,
   input  logic [AddrWidth-1:0] rd_addr_b,
   output logic [Width-1:0]     rd_data_a,
   output logic [Width-1:0]     rd_data_b
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== hw/rtl/mersenne_twister_generator_core.sv =====
// MT19937 generator core: seed and draw transactions over a 624-word state ram.
// In a seed transaction the seed word is written at accept, then ST_SEED writes one
// initializer word per cycle through a single 32x32 multiplier into the ram write
// port, then the result is returned. In a draw the ram reads the next word and the word
// 397 ahead at accept; ST_TWIST then, once the output is free, twists, writes back and
// tempers one word, so the block is twisted on the fly one word per draw. A draw before
// any seed first runs the full seeding from default_seed. Depends on mtg_pkg and
// mtg_state_ram.
module mersenne_twister_generator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  mtg_pkg::word_type req_seed_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mtg_pkg::word_type rsp_value,
   output logic             rsp_was_seed,
   input  logic             csr_wr_en,
   input  mtg_pkg::word_type csr_wr_data
);
   import mtg_pkg::*;

   fsm_state_type state_ff, state_in;
   word_type      default_seed_ff;
   idx_type       index_ff, index_in;
   idx_type       k_ff, k_in;
   idx_type       seed_pos_ff, seed_pos_in;
   word_type      prev_ff, prev_in;
   word_type      seed_ff, seed_in;
   word_type      cur_ff, cur_in;
   logic          kind_ff, kind_in;
   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_value_ff, rsp_value_in;
   logic          rsp_was_seed_ff, rsp_was_seed_in;

   logic     accept, seed_start, out_free, rsp_load;
   word_type start_seed, init_word, twisted;
   idx_type  k_now, nxt_addr, far_addr;
   logic     wr_en, rd_en;
   idx_type  wr_addr;
   word_type wr_data, rd_data_a, rd_data_b;

   mtg_state_ram #(
      .Depth(StateWords),
      .Width(WordWidth),
      .AddrWidth(IdxWidth)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr_a(nxt_addr),
      .rd_addr_b(far_addr),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign seed_start   = accept && ((req_kind == KIND_SEED) || (index_ff == NotSeeded));
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_was_seed = rsp_was_seed_ff;

   always_comb begin
      if (req_kind == KIND_SEED && req_seed_value != '0) begin
         start_seed = req_seed_value;
      end else begin
         start_seed = default_seed_ff;
      end
   end

   // word addresses for the next draw
   always_comb begin
      k_now    = (index_ff == BlockUsedUp) ? '0 : index_ff;
      nxt_addr = (k_now == LastWord) ? '0 : idx_type'(k_now + 1'b1);
      if (k_now < idx_type'(FarWrap)) begin
         far_addr = idx_type'(k_now + idx_type'(ShiftOffset));
      end else begin
         far_addr = idx_type'(k_now - idx_type'(FarWrap));
      end
   end

   assign init_word = init_next(prev_ff, seed_pos_ff);
   assign twisted   = twist_word(cur_ff, rd_data_a, rd_data_b);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (seed_start) begin
               state_in = ST_SEED;
            end else if (accept) begin
               state_in = ST_TWIST;
            end
         end
         ST_SEED: begin
            if (seed_pos_ff == LastWord) begin
               state_in = (kind_ff == KIND_DRAW) ? ST_READ : ST_SEED_DONE;
            end
         end
         ST_SEED_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_TWIST;
         end
         ST_TWIST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = init_word;
      rd_en           = 1'b0;
      rsp_load        = 1'b0;
      rsp_value_in    = rsp_value_ff;
      rsp_was_seed_in = rsp_was_seed_ff;
      index_in        = index_ff;
      k_in            = k_ff;
      seed_pos_in     = seed_pos_ff;
      prev_in         = prev_ff;
      seed_in         = seed_ff;
      cur_in          = cur_ff;
      kind_in         = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (seed_start) begin
               wr_en       = 1'b1;
               wr_addr     = '0;
               wr_data     = start_seed;
               seed_in     = start_seed;
               prev_in     = start_seed;
               seed_pos_in = idx_type'(1);
               kind_in     = req_kind;
            end else if (accept) begin
               rd_en = 1'b1;
               k_in  = k_now;
            end
         end
         ST_SEED: begin
            wr_en       = 1'b1;
            wr_addr     = seed_pos_ff;
            wr_data     = init_word;
            prev_in     = init_word;
            seed_pos_in = idx_type'(seed_pos_ff + 1'b1);
            if (seed_pos_ff == LastWord) begin
               index_in = BlockUsedUp;
               cur_in   = seed_ff;
            end
         end
         ST_SEED_DONE: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_value_in    = seed_ff;
               rsp_was_seed_in = 1'b1;
            end
         end
         ST_READ: begin
            rd_en = 1'b1;
            k_in  = k_now;
         end
         ST_TWIST: begin
            if (out_free) begin
               wr_en           = 1'b1;
               wr_addr         = k_ff;
               wr_data         = twisted;
               rsp_load        = 1'b1;
               rsp_value_in    = temper(twisted);
               rsp_was_seed_in = 1'b0;
               index_in        = idx_type'(k_ff + 1'b1);
               cur_in          = rd_data_a;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         default_seed_ff <= DefaultSeedInit;
         index_ff        <= NotSeeded;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            default_seed_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff            <= k_in;
      seed_pos_ff     <= seed_pos_in;
      prev_ff         <= prev_in;
      seed_ff         <= seed_in;
      cur_ff          <= cur_in;
      kind_ff         <= kind_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_was_seed_ff <= rsp_was_seed_in;
   end

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for mersenne_twister_generator_core: seed and draw transactions
// checked against an in-bench mt19937 predictor, with random idling on both channels
// depends on mtg_pkg and the generator core rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mtg_pkg::*;

   typedef struct packed {
      logic     kind;
      word_type seed_value;
   } gen_request_type;

   typedef struct packed {
      word_type value;
      logic     was_seed;
   } gen_result_type;

   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     req_valid      = 1'b0;
   logic     req_ready;
   logic     req_kind       = KIND_DRAW;
   word_type req_seed_value = '0;
   logic     rsp_valid;
   logic     rsp_ready      = 1'b0;
   word_type rsp_value;
   logic     rsp_was_seed;
   logic     csr_wr_en      = 1'b0;
   word_type csr_wr_data    = '0;

   // predictor state
   word_type twister_copy [StateWords];
   idx_type  draw_pos          = NotSeeded;
   word_type default_seed_copy = DefaultSeedInit;

   gen_request_type pending_requests[$];
   gen_result_type  expected_results[$];
   gen_request_type offered = '0;
   gen_result_type  want;
   bit offering   = 1'b0;
   bit steady     = 1'b0;
   int req_hold   = 0;
   int rsp_hold   = 0;
   int mismatches = 0;
   bit failed     = 1'b0;

   mersenne_twister_generator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_was_seed   (rsp_was_seed),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic void load_seed_words(word_type s);
      word_type p;
      twister_copy[0] = s;
      for (int i = 1; i < StateWords; i++) begin
         p = twister_copy[i-1];
         twister_copy[i] = InitMult * (p ^ (p >> 30)) + word_type'(i);
      end
      draw_pos = BlockUsedUp;
   endfunction

   function automatic gen_result_type advance_generator(gen_request_type r);
      gen_result_type res;
      word_type s;
      word_type y;
      if (r.kind == KIND_SEED) begin
         s = (r.seed_value == '0) ? default_seed_copy : r.seed_value;
         load_seed_words(s);
         res.value    = s;
         res.was_seed = 1'b1;
         return res;
      end
      if (draw_pos >= BlockUsedUp) begin
         if (draw_pos != BlockUsedUp) load_seed_words(default_seed_copy);
         for (int k = 0; k < StateWords; k++) begin
            y = {twister_copy[k][31], twister_copy[(k + 1) % StateWords][30:0]};
            twister_copy[k] = twister_copy[(k + ShiftOffset) % StateWords] ^ (y >> 1)
                              ^ (y[0] ? TwistXor : word_type'(0));
         end
         draw_pos = '0;
      end
      y = twister_copy[draw_pos];
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TemperMaskB);
      y = y ^ ((y << 15) & TemperMaskC);
      y = y ^ (y >> 18);
      res.value    = y;
      res.was_seed = 1'b0;
      draw_pos++;
      return res;
   endfunction

   function automatic int pick_idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_request(logic kind, word_type seed_value);
      pending_requests.push_back('{kind, seed_value});
   endfunction

   function automatic void queue_random_request();
      logic     kind;
      word_type seed_value;
      kind       = ($urandom_range(0, 3) == 0) ? KIND_SEED : KIND_DRAW;
      seed_value = $urandom();
      if (kind == KIND_SEED && $urandom_range(0, 2) == 0) seed_value = '0;
      queue_request(kind, seed_value);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         req_hold = pick_idle_cycles();
      end else begin
         if (offering && req_ready) begin
            expected_results.push_back(advance_generator(offered));
            offering = 1'b0;
            req_hold = pick_idle_cycles();
         end
         if (!offering) begin
            if (req_hold > 0) begin
               req_hold--;
            end else if (pending_requests.size() > 0) begin
               offered  = pending_requests.pop_front();
               offering = 1'b1;
               if ($urandom_range(0, 39) == 0) steady = !steady;
            end
         end
      end
      req_valid      <= offering;
      req_kind       <= offered.kind;
      req_seed_value <= offered.seed_value;
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               failed = 1'b1;
               if (mismatches <= 10)
                  $display("unexpected transaction: value %h was_seed %b",
                           rsp_value, rsp_was_seed);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value || rsp_was_seed !== want.was_seed) begin
                  mismatches++;
                  failed = 1'b1;
                  if (mismatches <= 10)
                     $display("mismatch: expected value %h was_seed %b, got value %h was_seed %b",
                              want.value, want.was_seed, rsp_value, rsp_was_seed);
               end
            end
            rsp_hold = pick_idle_cycles();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_hold = pick_idle_cycles();
         end
      end
      rsp_ready <= !reset && rsp_hold == 0;
   end

   task automatic wait_drained();
      while (pending_requests.size() != 0 || offering || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_default_seed(word_type v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      default_seed_copy = v;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // draws before any seed, then zero and extreme seeds
      queue_request(KIND_DRAW, 32'h1234_5678);
      queue_request(KIND_DRAW, 32'hffff_ffff);
      queue_request(KIND_SEED, 32'h0000_0000);
      queue_request(KIND_DRAW, 32'h0000_0000);
      queue_request(KIND_SEED, 32'h0000_0001);
      queue_request(KIND_DRAW, 32'h0000_0000);
      queue_request(KIND_SEED, 32'hffff_ffff);
      queue_request(KIND_DRAW, 32'h5555_5555);
      queue_request(KIND_DRAW, 32'haaaa_aaaa);
      queue_request(KIND_SEED, 32'h8000_0000);
      queue_request(KIND_DRAW, 32'h0000_0000);
      queue_request(KIND_SEED, 32'h7fff_ffff);
      queue_request(KIND_DRAW, 32'h0000_0000);
      wait_drained();

      // zero default seed
      write_default_seed('0);
      queue_request(KIND_SEED, 32'h0000_0000);
      queue_request(KIND_DRAW, 32'h0000_0000);
      queue_request(KIND_DRAW, 32'h0000_0000);
      queue_request(KIND_SEED, 32'h0000_1571);
      queue_request(KIND_DRAW, 32'h0000_0000);
      wait_drained();

      write_default_seed(32'hffff_ffff);
      queue_request(KIND_SEED, 32'h0000_0000);
      queue_request(KIND_DRAW, 32'h0000_0000);
      wait_drained();

      write_default_seed($urandom());
      queue_request(KIND_SEED, 32'h0000_0000);
      queue_request(KIND_DRAW, 32'h0000_0000);
      wait_drained();

      // short mixed runs, reseeding mid-block
      for (int ph = 0; ph < 3; ph++) begin
         write_default_seed((ph == 2) ? word_type'(0) : word_type'($urandom()));
         repeat (12) queue_random_request();
         wait_drained();
      end

      // one seed then enough draws to cross a block boundary
      write_default_seed($urandom());
      queue_request(KIND_SEED, $urandom());
      repeat (630) queue_request(KIND_DRAW, $urandom());
      wait_drained();

      write_default_seed(DefaultSeedInit);
      repeat (16) queue_random_request();
      wait_drained();

      repeat (20) @(posedge clock);
      if (!failed && expected_results.size() == 0)
         $display("** mersenne_twister_generator_core: PASSED **");
      else
         $display("** mersenne_twister_generator_core: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** mersenne_twister_generator_core: FAILED **");
      $finish;
   end

endmodule
